FILE: rtl/core/windowed_message_flow_control_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the windowed message flow control core
// ---------------------------------------------------------------------------
`ifndef WINDOWED_MESSAGE_FLOW_CONTROL_CORE_MACROS_SVH
`define WINDOWED_MESSAGE_FLOW_CONTROL_CORE_MACROS_SVH

// Check cons in the same cycle as ante.
`define WMFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define WMFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/wmfc_pkg.sv
// ---------------------------------------------------------------------------
// wmfc_pkg
// Types and codes shared by the windowed message flow control core.
// ---------------------------------------------------------------------------
package wmfc_pkg;

    localparam int WINDOW_WIDTH = 16;

    localparam logic [2:0] OP_START     = 3'd0;
    localparam logic [2:0] OP_REQ_SEND  = 3'd1;
    localparam logic [2:0] OP_GOT_INIT  = 3'd2;
    localparam logic [2:0] OP_GOT_RESP  = 3'd3;
    localparam logic [2:0] OP_GOT_REL   = 3'd4;
    localparam logic [2:0] OP_GOT_MSG   = 3'd5;
    localparam logic [2:0] OP_SEND_DONE = 3'd6;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_INIT  = 2'd1;
    localparam logic [1:0] ACT_RESP  = 2'd2;
    localparam logic [1:0] ACT_GRANT = 2'd3;

    localparam logic [1:0] PH_SEND_INIT = 2'd0;
    localparam logic [1:0] PH_SEND_RESP = 2'd1;
    localparam logic [1:0] PH_OPER      = 2'd2;
    localparam logic [1:0] PH_SEND_MSG  = 2'd3;

    localparam logic [15:0] RX_CAP_RESET = 16'd1024;
    localparam logic [15:0] HDR_BYTES    = 16'd2;

    typedef logic [WINDOW_WIDTH-1:0] window_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] value;
        logic        consumed;
    } item_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] advertised_window;
        logic [15:0] grant_size;
        logic [1:0]  phase;
        logic [15:0] peer_credit;
        logic        ignored;
        logic        rx_overflow;
    } result_t;

endpackage

FILE: rtl/core/wmfc_in_stage.sv
// ---------------------------------------------------------------------------
// wmfc_in_stage
// Input register: captures one word and holds it until the engine takes it.
// ---------------------------------------------------------------------------
module wmfc_in_stage
    import wmfc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/core/wmfc_engine.sv
// ---------------------------------------------------------------------------
// wmfc_engine
// Link state, receive capacity register and the per-word update logic.
// ---------------------------------------------------------------------------
`include "windowed_message_flow_control_core_macros.svh"

module wmfc_engine
    import wmfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,
    input  logic        fire,
    input  item_t       item,
    output result_t     res
);

    logic [1:0]  phase_reg,   phase_next;
    window_t     peer_reg,    peer_next;
    logic        pend_reg,    pend_next;
    logic [15:0] pend_sz_reg, pend_sz_next;
    logic        owed_reg,    owed_next;
    logic [15:0] occ_reg,     occ_next;
    logic [15:0] cap_reg;

    logic        do_np;
    logic [16:0] cons_cost;
    logic [17:0] msg_fill;
    window_t     send_cost;
    window_t     pend_cost;

    assign cons_cost = {1'b0, item.value} + {1'b0, HDR_BYTES};
    assign msg_fill  = {2'b00, occ_reg} + {2'b00, item.value} + {2'b00, HDR_BYTES};
    assign send_cost = window_t'(item.value) + window_t'(HDR_BYTES);

    always_comb
    begin
        phase_next   = phase_reg;
        peer_next    = peer_reg;
        pend_next    = pend_reg;
        pend_sz_next = pend_sz_reg;
        owed_next    = owed_reg;
        occ_next     = occ_reg;
        do_np        = 1'b0;
        res          = '0;

        if (item.consumed)
        begin
            occ_next = ({1'b0, occ_reg} > cons_cost) ?
                       occ_reg - cons_cost[15:0] : 16'd0;
        end
        else
        begin
            case (item.operation)
                OP_START:
                begin
                    phase_next   = PH_SEND_INIT;
                    peer_next    = '0;
                    pend_next    = 1'b0;
                    pend_sz_next = '0;
                    owed_next    = 1'b0;
                    occ_next     = '0;
                    res.action   = ACT_INIT;
                    res.advertised_window = cap_reg;
                end
                OP_REQ_SEND:
                begin
                    pend_next    = 1'b1;
                    pend_sz_next = item.value;
                    do_np        = (phase_reg == PH_OPER);
                end
                OP_GOT_INIT:
                begin
                    if (phase_reg != PH_SEND_MSG)
                    begin
                        peer_next = window_t'(item.value);
                    end
                    owed_next = 1'b1;
                    do_np     = (phase_reg == PH_OPER);
                end
                OP_GOT_RESP:
                begin
                    if (phase_reg == PH_SEND_INIT)
                    begin
                        res.ignored = 1'b1;
                    end
                    else
                    begin
                        peer_next = window_t'(item.value);
                        do_np     = (phase_reg == PH_OPER);
                    end
                end
                OP_GOT_REL:
                begin
                    if (phase_reg == PH_SEND_INIT || phase_reg == PH_SEND_RESP)
                    begin
                        res.ignored = 1'b1;
                    end
                    else
                    begin
                        peer_next = peer_reg + window_t'(item.value);
                        do_np     = (phase_reg == PH_OPER);
                    end
                end
                OP_GOT_MSG:
                begin
                    if (phase_reg == PH_SEND_INIT)
                    begin
                        res.ignored = 1'b1;
                    end
                    else if (msg_fill > {2'b00, cap_reg})
                    begin
                        occ_next        = cap_reg;
                        res.rx_overflow = 1'b1;
                    end
                    else
                    begin
                        occ_next = msg_fill[15:0];
                    end
                end
                OP_SEND_DONE:
                begin
                    if (phase_reg == PH_OPER)
                    begin
                        res.ignored = 1'b1;
                    end
                    else
                    begin
                        if (phase_reg == PH_SEND_MSG)
                        begin
                            peer_next = peer_reg - send_cost;
                        end
                        do_np = 1'b1;
                    end
                end
                default:
                begin
                    res.ignored = 1'b1;
                end
            endcase
        end

        // pick the next phase from the updated state
        pend_cost = window_t'(pend_sz_next) + window_t'(HDR_BYTES);
        if (do_np)
        begin
            if (owed_next)
            begin
                phase_next            = PH_SEND_RESP;
                res.action            = ACT_RESP;
                res.advertised_window = (cap_reg > occ_next) ? cap_reg - occ_next : 16'd0;
            end
            else if (pend_next && (pend_cost <= peer_next))
            begin
                phase_next     = PH_SEND_MSG;
                res.action     = ACT_GRANT;
                res.grant_size = pend_sz_next;
                pend_next      = 1'b0;
                pend_sz_next   = '0;
            end
            else
            begin
                phase_next = PH_OPER;
            end
            owed_next = 1'b0;
        end

        res.phase       = phase_next;
        res.peer_credit = 16'(peer_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SEND_INIT;
            peer_reg    <= '0;
            pend_reg    <= 1'b0;
            pend_sz_reg <= '0;
            owed_reg    <= 1'b0;
            occ_reg     <= '0;
            cap_reg     <= RX_CAP_RESET;
        end
        else
        begin
            if (cfg_wen)
            begin
                cap_reg <= cfg_wdata;
            end
            if (fire)
            begin
                phase_reg   <= phase_next;
                peer_reg    <= peer_next;
                pend_reg    <= pend_next;
                pend_sz_reg <= pend_sz_next;
                owed_reg    <= owed_next;
                occ_reg     <= occ_next;
            end
        end
    end

    `WMFC_ASSERT_NEXT(a_grant_enters_send, fire && res.action == ACT_GRANT, phase_reg == PH_SEND_MSG && !pend_reg, "grant did not enter send phase")
    `WMFC_ASSERT_NEXT(a_start_clears, fire && res.action == ACT_INIT, peer_reg == '0 && occ_reg == 16'd0 && !owed_reg, "start left state behind")
    `WMFC_ASSERT_NEXT(a_consume_keeps_phase, fire && item.consumed, phase_reg == $past(phase_reg) && peer_reg == $past(peer_reg), "consumption changed link state")
    `WMFC_ASSERT_NOW(a_overflow_saturates, fire && res.rx_overflow, occ_next == cap_reg, "overflow did not saturate occupancy")

endmodule

FILE: rtl/core/wmfc_out_stage.sv
// ---------------------------------------------------------------------------
// wmfc_out_stage
// Result register: holds one result word until the sink takes it.
// ---------------------------------------------------------------------------
module wmfc_out_stage
    import wmfc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  result_t res,
    output logic    advance,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // take a new result when empty or when the held one leaves now
    assign advance    = item_valid && (!valid_reg || out_ready);
    assign valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

FILE: rtl/core/windowed_message_flow_control_core.sv
// ---------------------------------------------------------------------------
// windowed_message_flow_control_core
// Credit-window link controller: phases, peer credit and receive occupancy.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  input    | in_valid / in_ready  | operation, value, consumed
//  result   | out_valid / out_ready| action, advertised_window, grant_size,
//           |                      | phase, peer_credit, ignored, rx_overflow
//  config   | cfg_wen              | cfg_wdata (rx_capacity)
//
//  One word per cycle sustained while out_ready is high; an accepted word
//  passes from the input register through the update logic into the
//  result register. Link state updates as the word enters the result register.
//  Reset clears all state and sets rx_capacity to 1024.
//  A stalled result holds the input register, and in_ready drops once it is full.
// ---------------------------------------------------------------------------
module windowed_message_flow_control_core
    import wmfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [15:0] value,
    input  logic        consumed,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  action,
    output logic [15:0] advertised_window,
    output logic [15:0] grant_size,
    output logic [1:0]  phase,
    output logic [15:0] peer_credit,
    output logic        ignored,
    output logic        rx_overflow
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t res;
    result_t out_res;

    assign in_item.operation = operation;
    assign in_item.value     = value;
    assign in_item.consumed  = consumed;

    wmfc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    wmfc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .fire      (advance),
        .item      (item),
        .res       (res)
    );

    wmfc_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .res        (res),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_res    (out_res)
    );

    assign action            = out_res.action;
    assign advertised_window = out_res.advertised_window;
    assign grant_size        = out_res.grant_size;
    assign phase             = out_res.phase;
    assign peer_credit       = out_res.peer_credit;
    assign ignored           = out_res.ignored;
    assign rx_overflow       = out_res.rx_overflow;

endmodule
